/* rtl/tmvid_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package tmvid_pkg;

	typedef struct packed {
		logic        mode;
		logic        tile_start;
		logic [15:0] coded_u;
		logic [15:0] coded_v;
		logic [15:0] coded_height;
		logic [31:0] index_code;
	} req_t;

	typedef struct packed {
		logic               is_index;
		logic [15:0]        x_coord;
		logic signed [15:0] y_coord;
		logic signed [31:0] elevation;
		logic [31:0]        vertex_index;
	} res_t;

	typedef struct packed {
		logic step;
		logic clear;
	} lane_ctl_t;

	typedef enum logic {
		REG_MIN_HEIGHT = 1'b0,
		REG_MAX_HEIGHT = 1'b1
	} reg_idx_t;

	localparam logic [15:0] Y_ONE        = 16'h7FFF;
	localparam logic [14:0] HEIGHT_SCALE = 15'h7FFF;

	function automatic logic [15:0] unzigzag(input logic [15:0] c);
		return {1'b0, c[15:1]} ^ {16{c[0]}};
	endfunction

endpackage

`default_nettype wire

/* rtl/tmvid_lane.sv */
`timescale 1ns / 1ps
`default_nettype none

module tmvid_lane (
	input  logic                  clk,
	input  logic                  arst_n,
	input  tmvid_pkg::lane_ctl_t  ctl,
	input  logic [15:0]           code,
	output logic [15:0]           acc_next
);
	import tmvid_pkg::*;

	logic [15:0] acc_q;
	logic [15:0] base;

	assign base     = ctl.clear ? 16'h0000 : acc_q;
	assign acc_next = base + unzigzag(code);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= 16'h0000;
		end else if (ctl.step) begin
			acc_q <= acc_next;
		end else if (ctl.clear) begin
			acc_q <= 16'h0000;
		end
	end

endmodule

`default_nettype wire

/* rtl/tmvid_elev.sv */
`timescale 1ns / 1ps
`default_nettype none

module tmvid_elev (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [15:0]         in_height,
	input  tmvid_pkg::res_t     in_res,
	input  logic signed [31:0]  min_height,
	input  logic signed [31:0]  max_height,
	output logic                out_valid,
	input  logic                out_ready,
	output tmvid_pkg::res_t     out_res
);
	import tmvid_pkg::*;

	localparam logic signed [35:0] E_MAX = 36'sd2147483647;
	localparam logic signed [35:0] E_MIN = -36'sd2147483648;

	logic v2_q, v3_q, v4_q, v5_q, vo_q;
	logic rdy2, rdy3, rdy4, rdy5, rdyo;

	// span magnitude and sign from the stable tile limits
	logic [32:0] span_p;
	logic [32:0] span_n;
	logic [31:0] span_mag;
	logic [47:0] prod_w;

	logic [47:0] prod_s2;
	logic        neg_s2;
	res_t        res_s2;

	logic [33:0] r1_w;
	logic [32:0] q1_s3;
	logic [33:0] r1_s3;
	logic        neg_s3;
	res_t        res_s3;

	logic [18:0] hi2;
	logic [19:0] r2_w;
	logic [33:0] q2_w;
	logic [19:0] r2_s4;
	logic [33:0] q2_s4;
	logic        neg_s4;
	res_t        res_s4;

	logic [4:0]  hi3;
	logic [15:0] r3_w;
	logic        corr;
	logic [33:0] q_w;
	logic [33:0] q_s5;
	logic        neg_s5;
	res_t        res_s5;

	logic signed [35:0] min_x;
	logic signed [35:0] q_x;
	logic signed [35:0] sum_w;
	logic signed [31:0] elev_w;
	res_t               res_o_w;
	res_t               res_q;

	assign rdyo     = !vo_q || out_ready;
	assign rdy5     = !v5_q || rdyo;
	assign rdy4     = !v4_q || rdy5;
	assign rdy3     = !v3_q || rdy4;
	assign rdy2     = !v2_q || rdy3;
	assign in_ready = rdy2;

	assign span_p   = {max_height[31], max_height} - {min_height[31], min_height};
	assign span_n   = {min_height[31], min_height} - {max_height[31], max_height};
	assign span_mag = span_p[32] ? span_n[31:0] : span_p[31:0];
	assign prod_w   = {16'h0000, span_mag} * {32'h0000_0000, in_height};

	// divide by 2^15-1: fold high part onto low part, quotient is the sum of high parts
	assign r1_w = {1'b0, prod_s2[47:15]} + {19'h00000, prod_s2[14:0]};

	assign hi2  = r1_s3[33:15];
	assign r2_w = {1'b0, hi2} + {5'h00, r1_s3[14:0]};
	assign q2_w = {1'b0, q1_s3} + {15'h0000, hi2};

	assign hi3  = r2_s4[19:15];
	assign r3_w = {11'h000, hi3} + {1'b0, r2_s4[14:0]};
	assign corr = (r3_w >= {1'b0, HEIGHT_SCALE});
	assign q_w  = q2_s4 + {29'h0000_0000, hi3} + {33'h0_0000_0000, corr};

	assign min_x = {{4{min_height[31]}}, min_height};
	assign q_x   = {2'b00, q_s5};
	assign sum_w = neg_s5 ? (min_x - q_x) : (min_x + q_x);

	always_comb begin
		priority if (sum_w > E_MAX) begin
			elev_w = 32'sh7FFF_FFFF;
		end else if (sum_w < E_MIN) begin
			elev_w = 32'sh8000_0000;
		end else begin
			elev_w = sum_w[31:0];
		end
	end

	always_comb begin
		res_o_w           = res_s5;
		res_o_w.elevation = res_s5.is_index ? 32'sh0000_0000 : elev_w;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v2_q <= 1'b0;
			v3_q <= 1'b0;
			v4_q <= 1'b0;
			v5_q <= 1'b0;
			vo_q <= 1'b0;
		end else begin
			if (rdy2) begin
				v2_q <= in_valid;
			end
			if (rdy3) begin
				v3_q <= v2_q;
			end
			if (rdy4) begin
				v4_q <= v3_q;
			end
			if (rdy5) begin
				v5_q <= v4_q;
			end
			if (rdyo) begin
				vo_q <= v5_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy2) begin
			prod_s2 <= prod_w;
			neg_s2  <= span_p[32];
			res_s2  <= in_res;
		end
		if (rdy3) begin
			q1_s3  <= prod_s2[47:15];
			r1_s3  <= r1_w;
			neg_s3 <= neg_s2;
			res_s3 <= res_s2;
		end
		if (rdy4) begin
			r2_s4  <= r2_w;
			q2_s4  <= q2_w;
			neg_s4 <= neg_s3;
			res_s4 <= res_s3;
		end
		if (rdy5) begin
			q_s5   <= q_w;
			neg_s5 <= neg_s4;
			res_s5 <= res_s4;
		end
		if (rdyo) begin
			res_q <= res_o_w;
		end
	end

	assign out_valid = vo_q;
	assign out_res   = res_q;

	a_index_no_elev: assert property (@(posedge clk) disable iff (!arst_n)
		vo_q && res_q.is_index |-> res_q.elevation == 32'sh0000_0000)
		else $error("index result carries elevation");

	a_s5_holds: assert property (@(posedge clk) disable iff (!arst_n)
		v5_q && !rdyo |=> v5_q && $stable(q_s5) && $stable(res_s5))
		else $error("stage 5 lost under stall");

	a_s3_holds: assert property (@(posedge clk) disable iff (!arst_n)
		v3_q && !rdy4 |=> v3_q && $stable(r1_s3) && $stable(q1_s3))
		else $error("stage 3 lost under stall");

endmodule

`default_nettype wire

/* rtl/terrain_mesh_vertex_index_decoder.sv */
// throughput: one request per cycle unless stalled
// accumulators update at acceptance
// the elevation path is a 5-stage pipeline (multiply, two folds, quotient, saturate)
// bubbles collapse, so requests are taken while a result waits on the output
// reset clears accumulators, high-water mark, tile limits and all valid bits
`timescale 1ns / 1ps
`default_nettype none

module terrain_mesh_vertex_index_decoder (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  tmvid_pkg::req_t   req,
	output logic              res_valid,
	input  logic              res_ready,
	output tmvid_pkg::res_t   res,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);
	import tmvid_pkg::*;

	logic signed [31:0] min_q;
	logic signed [31:0] max_q;
	logic               cfg_wr;

	logic        accept;
	lane_ctl_t   lane_ctl;
	logic [15:0] u_next, v_next, h_next;

	logic [31:0] mark_q;
	logic [31:0] mark_base;
	logic [31:0] idx_w;

	res_t        side_w;
	logic        v1_q;
	res_t        side_s1;
	logic [15:0] h_s1;
	logic        elev_ready;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= 32'sh0000_0000;
			max_q <= 32'sh0000_0000;
		end else if (cfg_wr) begin
			unique case (reg_idx_t'(paddr[2]))
				REG_MIN_HEIGHT: min_q <= pwdata;
				REG_MAX_HEIGHT: max_q <= pwdata;
				default:        min_q <= min_q;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx_t'(paddr[2]))
			REG_MIN_HEIGHT: prdata = min_q;
			REG_MAX_HEIGHT: prdata = max_q;
			default:        prdata = 32'h0000_0000;
		endcase
	end

	assign req_ready      = !v1_q || elev_ready;
	assign accept         = req_valid && req_ready;
	assign lane_ctl.step  = accept && !req.mode;
	assign lane_ctl.clear = accept && req.tile_start;

	tmvid_lane u_lane_u (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (lane_ctl),
		.code     (req.coded_u),
		.acc_next (u_next)
	);

	tmvid_lane u_lane_v (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (lane_ctl),
		.code     (req.coded_v),
		.acc_next (v_next)
	);

	tmvid_lane u_lane_h (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (lane_ctl),
		.code     (req.coded_height),
		.acc_next (h_next)
	);

	// high-water mark index decode
	assign mark_base = req.tile_start ? 32'h0000_0000 : mark_q;
	assign idx_w     = mark_base - req.index_code;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mark_q <= 32'h0000_0000;
		end else if (accept && req.mode) begin
			mark_q <= mark_base + {31'h0000_0000, (req.index_code == 32'h0000_0000)};
		end else if (accept && req.tile_start) begin
			mark_q <= 32'h0000_0000;
		end
	end

	always_comb begin
		side_w              = '0;
		side_w.is_index     = req.mode;
		side_w.x_coord      = req.mode ? 16'h0000 : u_next;
		side_w.y_coord      = req.mode ? 16'sh0000 : (Y_ONE - v_next);
		side_w.vertex_index = req.mode ? idx_w : 32'h0000_0000;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
		end else if (req_ready) begin
			v1_q <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			side_s1 <= side_w;
			h_s1    <= h_next;
		end
	end

	tmvid_elev u_elev (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (v1_q),
		.in_ready   (elev_ready),
		.in_height  (h_s1),
		.in_res     (side_s1),
		.min_height (min_q),
		.max_height (max_q),
		.out_valid  (res_valid),
		.out_ready  (res_ready),
		.out_res    (res)
	);

	a_mark_bump: assert property (@(posedge clk) disable iff (!arst_n)
		accept && req.mode && !req.tile_start && req.index_code == 32'h0000_0000
		|=> mark_q == $past(mark_q) + 32'h0000_0001)
		else $error("high-water mark not bumped");

	a_vertex_no_index: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.is_index |-> res.vertex_index == 32'h0000_0000)
		else $error("vertex result carries index");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		v1_q && !elev_ready |=> v1_q && $stable(side_s1) && $stable(h_s1))
		else $error("stage 1 lost under stall");

endmodule

`default_nettype wire

/* test/tb_terrain_mesh_vertex_index_decoder.sv */
`timescale 1ns / 1ps

module tb_terrain_mesh_vertex_index_decoder;
	import tmvid_pkg::*;

	localparam logic   MODE_VERTEX   = 1'b0;
	localparam logic   MODE_INDEX    = 1'b1;
	localparam int     PRESSURE_A    = 150;
	localparam int     PRESSURE_B    = 1100;
	localparam int     PRESSURE_HOLD = 120;
	localparam longint ELEV_HI       = 64'sd2147483647;
	localparam longint ELEV_LO       = -64'sd2147483648;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        req_valid = 1'b0;
	logic        req_ready;
	req_t        req       = '0;
	logic        res_valid;
	logic        res_ready = 1'b0;
	res_t        res;
	logic        psel      = 1'b0;
	logic        penable   = 1'b0;
	logic        pwrite    = 1'b0;
	logic [2:0]  paddr     = '0;
	logic [31:0] pwdata    = '0;
	logic [31:0] prdata;
	logic        pready;

	req_t mesh_words[$];
	res_t decoded_queue[$];

	logic signed [31:0] tile_min   = '0;
	logic signed [31:0] tile_max   = '0;
	logic [15:0]        u_sum      = '0;
	logic [15:0]        v_sum      = '0;
	logic [15:0]        h_sum      = '0;
	logic [31:0]        water_mark = '0;

	int mismatches   = 0;
	int results_seen = 0;
	int send_gap     = 0;
	int take_hold    = 0;
	bit send_calm    = 1'b0;
	bit take_calm    = 1'b0;

	terrain_mesh_vertex_index_decoder uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [15:0] zigzag_delta(input logic [15:0] code);
		logic [15:0] half;
		half = code >> 1;
		return code[0] ? ~half : half;
	endfunction

	function automatic logic signed [31:0] lerp_elevation(input logic [15:0] h);
		longint span;
		longint scaled;
		longint e;
		span = longint'(tile_max) - longint'(tile_min);
		scaled = span * longint'(h);
		e = longint'(tile_min) + scaled / longint'(HEIGHT_SCALE);
		if (e > ELEV_HI)
			e = ELEV_HI;
		if (e < ELEV_LO)
			e = ELEV_LO;
		return e[31:0];
	endfunction

	function automatic res_t decode_mesh_item(input req_t r);
		res_t d;
		d = '0;
		if (r.tile_start) begin
			u_sum = '0;
			v_sum = '0;
			h_sum = '0;
			water_mark = '0;
		end
		d.is_index = r.mode;
		if (r.mode == MODE_INDEX) begin
			d.vertex_index = water_mark - r.index_code;
			if (r.index_code == '0)
				water_mark = water_mark + 32'd1;
		end else begin
			u_sum = u_sum + zigzag_delta(r.coded_u);
			v_sum = v_sum + zigzag_delta(r.coded_v);
			h_sum = h_sum + zigzag_delta(r.coded_height);
			d.x_coord = u_sum;
			d.y_coord = Y_ONE - v_sum;
			d.elevation = lerp_elevation(h_sum);
		end
		return d;
	endfunction

	function automatic int pick_idle(input bit calm);
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	function automatic logic [15:0] rand_delta();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 16'($urandom_range(0, 63));
		if (r < 85)
			return 16'($urandom);
		case ($urandom_range(0, 3))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return 16'hFFFE;
			default: return 16'h0001;
		endcase
	endfunction

	function automatic logic [31:0] rand_index_code();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return '0;
		if (r < 90)
			return 32'($urandom_range(1, 12));
		return $urandom;
	endfunction

	task automatic queue_item(input logic mode, input logic start, input logic [15:0] du,
			input logic [15:0] dv, input logic [15:0] dh, input logic [31:0] code);
		req_t r;
		r.mode = mode;
		r.tile_start = start;
		r.coded_u = du;
		r.coded_v = dv;
		r.coded_height = dh;
		r.index_code = code;
		mesh_words.push_back(r);
	endtask

	// tiles of vertices followed by their indices, with some noise mixed in
	task automatic fill_random(input int count);
		int n;
		int nv;
		int ni;
		n = 0;
		while (n < count) begin
			if ($urandom_range(0, 9) == 0) begin
				queue_item(1'($urandom), 1'($urandom), 16'($urandom), 16'($urandom),
					16'($urandom), $urandom);
				n++;
			end else begin
				nv = $urandom_range(1, 40);
				ni = $urandom_range(0, 60);
				for (int i = 0; i < nv + ni && n < count; i++) begin
					if (i < nv)
						queue_item(MODE_VERTEX, i == 0, rand_delta(), rand_delta(),
							rand_delta(), $urandom);
					else
						queue_item(MODE_INDEX, i == 0, 16'($urandom), 16'($urandom),
							16'($urandom), rand_index_code());
					n++;
				end
			end
		end
	endtask

	task automatic set_limit(input reg_idx_t idx, input logic signed [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(negedge clk);
		while (!pready)
			@(negedge clk);
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == REG_MIN_HEIGHT)
			tile_min = value;
		else
			tile_max = value;
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (mesh_words.size() != 0 || req_valid || decoded_queue.size() != 0);
		repeat (6) @(posedge clk);
	endtask

	always @(posedge clk or negedge arst_n) begin
		logic next_valid;
		if (!arst_n) begin
			req_valid <= 1'b0;
			req <= '0;
			send_gap <= 0;
		end else begin
			next_valid = req_valid;
			if (req_valid && req_ready) begin
				decoded_queue.push_back(decode_mesh_item(req));
				next_valid = 1'b0;
			end
			if (!next_valid) begin
				if (send_gap != 0) begin
					send_gap <= send_gap - 1;
				end else if (mesh_words.size() != 0) begin
					req <= mesh_words.pop_front();
					next_valid = 1'b1;
					send_gap <= pick_idle(send_calm);
				end
			end
			req_valid <= next_valid;
			if ($urandom_range(0, 149) == 0)
				send_calm <= ~send_calm;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		res_t want;
		int idle;
		if (!arst_n) begin
			res_ready <= 1'b0;
			take_hold <= 0;
			results_seen <= 0;
		end else begin
			if (res_valid && res_ready) begin
				if (decoded_queue.size() == 0) begin
					$error("result with no request pending");
					mismatches++;
				end else begin
					want = decoded_queue.pop_front();
					if (res.is_index !== want.is_index) begin
						$error("is_index expected %0d got %0d", want.is_index, res.is_index);
						mismatches++;
					end
					if (res.x_coord !== want.x_coord) begin
						$error("x_coord expected %0d got %0d", want.x_coord, res.x_coord);
						mismatches++;
					end
					if (res.y_coord !== want.y_coord) begin
						$error("y_coord expected %0d got %0d", want.y_coord, res.y_coord);
						mismatches++;
					end
					if (res.elevation !== want.elevation) begin
						$error("elevation expected %0d got %0d", want.elevation,
							res.elevation);
						mismatches++;
					end
					if (res.vertex_index !== want.vertex_index) begin
						$error("vertex_index expected %0d got %0d", want.vertex_index,
							res.vertex_index);
						mismatches++;
					end
				end
				results_seen <= results_seen + 1;
			end
			if (res_valid && res_ready &&
					(results_seen + 1 == PRESSURE_A || results_seen + 1 == PRESSURE_B)) begin
				res_ready <= 1'b0;
				take_hold <= PRESSURE_HOLD;
			end else if (take_hold != 0) begin
				res_ready <= 1'b0;
				take_hold <= take_hold - 1;
			end else begin
				idle = pick_idle(take_calm);
				res_ready <= (idle == 0);
				take_hold <= (idle == 0) ? 0 : idle - 1;
			end
			if ($urandom_range(0, 149) == 0)
				take_calm <= ~take_calm;
		end
	end

	initial begin
		logic signed [31:0] same;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		fill_random(200);
		wait_drained();

		set_limit(REG_MIN_HEIGHT, 32'sh80000000);
		set_limit(REG_MAX_HEIGHT, 32'sh7FFFFFFF);
		queue_item(MODE_VERTEX, 1'b1, 16'h0000, 16'h0000, 16'h0000, 32'h0000_0000);
		queue_item(MODE_VERTEX, 1'b0, 16'hFFFE, 16'hFFFE, 16'hFFFE, 32'hFFFF_FFFF);
		queue_item(MODE_VERTEX, 1'b0, 16'h0002, 16'h0002, 16'h0002, 32'h0000_0000);
		queue_item(MODE_VERTEX, 1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'h0000_0000);
		queue_item(MODE_VERTEX, 1'b0, 16'h0001, 16'h0001, 16'h0001, 32'h0000_0000);
		queue_item(MODE_VERTEX, 1'b0, 16'h0000, 16'h0000, 16'h0000, 32'hFFFF_FFFF);
		queue_item(MODE_INDEX, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'h0000_0000);
		queue_item(MODE_INDEX, 1'b0, 16'h0000, 16'h0000, 16'h0000, 32'h0000_0000);
		queue_item(MODE_INDEX, 1'b0, 16'h0000, 16'h0000, 16'h0000, 32'h0000_0001);
		queue_item(MODE_INDEX, 1'b0, 16'h0000, 16'h0000, 16'h0000, 32'h0000_0002);
		queue_item(MODE_INDEX, 1'b0, 16'h0000, 16'h0000, 16'h0000, 32'hFFFF_FFFF);
		queue_item(MODE_INDEX, 1'b0, 16'h0000, 16'h0000, 16'h0000, 32'h8000_0000);
		queue_item(MODE_VERTEX, 1'b1, 16'h0002, 16'h0004, 16'h0006, 32'hFFFF_FFFF);
		queue_item(MODE_INDEX, 1'b0, 16'h0000, 16'h0000, 16'h0000, 32'h0000_0000);
		queue_item(MODE_VERTEX, 1'b0, 16'hAAAA, 16'h5555, 16'hAAAA, 32'h5555_5555);
		queue_item(MODE_INDEX, 1'b1, 16'h5555, 16'hAAAA, 16'h5555, 32'h1234_5678);
		queue_item(MODE_VERTEX, 1'b0, 16'h8000, 16'h7FFF, 16'h4000, 32'hAAAA_AAAA);
		fill_random(400);
		wait_drained();

		// reversed limits push extrapolated heights to the low rail
		set_limit(REG_MIN_HEIGHT, 32'sh7FFFFFFF);
		set_limit(REG_MAX_HEIGHT, 32'sh80000000);
		fill_random(400);
		wait_drained();

		set_limit(REG_MIN_HEIGHT, -32'sd256000);
		set_limit(REG_MAX_HEIGHT, 32'sd768000);
		fill_random(400);
		wait_drained();

		set_limit(REG_MIN_HEIGHT, $urandom);
		set_limit(REG_MAX_HEIGHT, $urandom);
		fill_random(300);
		wait_drained();

		same = $urandom;
		set_limit(REG_MIN_HEIGHT, same);
		set_limit(REG_MAX_HEIGHT, same);
		fill_random(200);
		wait_drained();

		repeat (10) @(posedge clk);
		if (mismatches == 0 && decoded_queue.size() == 0)
			$display("terrain_mesh_vertex_index_decoder: match");
		else
			$display("terrain_mesh_vertex_index_decoder: mismatch");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("terrain_mesh_vertex_index_decoder: mismatch");
		$finish;
	end

endmodule
